[design/glob_pattern_matcher_macros.svh]
// Assertion macros for the glob pattern matcher.
// Used by the top level; no other dependencies.
`ifndef GLOB_PATTERN_MATCHER_MACROS_SVH
`define GLOB_PATTERN_MATCHER_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define GPM_ASSERT_IMP(lbl, a, c) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (a) |-> (c)) \
	else $error("assertion failed");
// Implication checked in the cycle after the antecedent.
`define GPM_ASSERT_NXT(lbl, a, c) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (a) |=> (c)) \
	else $error("assertion failed");
`endif

[design/gpm_pkg.sv]
// Package for the glob pattern matcher: sizes, operation codes, states.
// No dependencies.
`default_nettype none
package gpm_pkg;
	localparam int PATTERN_MAX = 256;
	localparam int VALUE_MAX = 4096;
	localparam int PAW = $clog2(PATTERN_MAX);
	localparam int VAW = $clog2(VALUE_MAX);
	localparam int PLW = $clog2(PATTERN_MAX + 1);
	localparam int VLW = $clog2(VALUE_MAX + 1);

	typedef enum logic [1:0] {
		OP_PAT = 2'd0,
		OP_VAL = 2'd1,
		OP_EVAL = 2'd2,
		OP_CLR = 2'd3
	} op_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_CHK_RD, ST_CHK,
		ST_M_RD, ST_M,
		ST_ESC_RD, ST_ESC,
		ST_CL_RD, ST_CL,
		ST_CL_LO, ST_CL_LOE,
		ST_CL_DASH, ST_CL_DASH2,
		ST_CL_HI, ST_CL_HIE,
		ST_TAIL_RD, ST_TAIL,
		ST_DONE
	} state_t;

	localparam logic [7:0] CH_STAR = 8'h2a;
	localparam logic [7:0] CH_QM = 8'h3f;
	localparam logic [7:0] CH_LB = 8'h5b;
	localparam logic [7:0] CH_RB = 8'h5d;
	localparam logic [7:0] CH_BANG = 8'h21;
	localparam logic [7:0] CH_CARET = 8'h5e;
	localparam logic [7:0] CH_DASH = 8'h2d;
	localparam logic [7:0] CH_BSL = 8'h5c;
	localparam logic [7:0] CH_SP = 8'h20;
	localparam logic [7:0] CH_DEL = 8'h7f;
endpackage
`default_nettype wire

[design/glob_pattern_matcher.sv]
// Glob pattern matcher top level: pattern and value memories and the walk sequencer.
// Depends on gpm_pkg and glob_pattern_matcher_macros.svh.
//
// Append and clear beats are taken while busy stays low. An evaluate
// beat raises busy for a walk over the pattern memory (validity check, with a
// read and a check state per pattern byte, and the byte after a '[' or negation
// mark examined again when it is not consumed) and then the match walk. A match
// step that compares one value byte passes ST_M_RD, ST_M and ST_CL_DASH2, a star
// only the first two, escapes and classes more states; it backtracks to the last star seen, so its length grows with
// pattern length times value length in the worst case. The result is shown for
// one cycle on done; it cannot be stalled. No clearing pass is needed after reset.
`default_nettype none
`include "glob_pattern_matcher_macros.svh"
module glob_pattern_matcher (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	output logic busy,
	input wire logic [1:0] operation,
	input wire logic [7:0] data_byte,
	output logic done,
	output logic matched,
	output logic pattern_valid,
	output logic overflow
);
	logic [7:0] pmem [gpm_pkg::PATTERN_MAX];
	logic [7:0] vmem [gpm_pkg::VALUE_MAX];
	logic [7:0] prd_q, vrd_q;
	logic [gpm_pkg::PAW-1:0] praddr;
	logic [gpm_pkg::VAW-1:0] vraddr;

	gpm_pkg::state_t st_q, st_d;
	logic [gpm_pkg::PLW-1:0] plen_q;
	logic [gpm_pkg::VLW-1:0] vlen_q;
	logic ptl_q, vtl_q;

	// walk registers
	logic [gpm_pkg::PLW:0] pi_q, pi_d, spi_q, spi_d, cs_q, cs_d;
	logic [gpm_pkg::VLW-1:0] vi_q, vi_d, svi_q, svi_d;
	logic hs_q, hs_d, neg_q, neg_d, hit_q, hit_d, mode_q, mode_d;
	logic [1:0] sub_q, sub_d;
	logic [7:0] lo_q, lo_d, c_q, c_d;
	logic valid_q, valid_d, res_q, res_d;
	logic [gpm_pkg::PLW:0] rd_i;

	logic acc;
	assign acc = start && !busy;

	// memories
	always_ff @(posedge clk) begin
		if (acc && gpm_pkg::op_t'(operation) == gpm_pkg::OP_PAT && !plen_q[gpm_pkg::PLW-1])
			pmem[plen_q[gpm_pkg::PAW-1:0]] <= data_byte;
		if (acc && gpm_pkg::op_t'(operation) == gpm_pkg::OP_VAL && !vlen_q[gpm_pkg::VLW-1])
			vmem[vlen_q[gpm_pkg::VAW-1:0]] <= data_byte;
		prd_q <= pmem[praddr];
		vrd_q <= vmem[vraddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= gpm_pkg::ST_IDLE;
			plen_q <= '0;
			vlen_q <= '0;
			ptl_q <= 1'b0;
			vtl_q <= 1'b0;
		end else begin
			st_q <= st_d;
			if (acc) begin
				case (gpm_pkg::op_t'(operation))
					gpm_pkg::OP_PAT: begin
						if (plen_q[gpm_pkg::PLW-1]) ptl_q <= 1'b1;
						else plen_q <= plen_q + 1'b1;
					end
					gpm_pkg::OP_VAL: begin
						if (vlen_q[gpm_pkg::VLW-1]) vtl_q <= 1'b1;
						else vlen_q <= vlen_q + 1'b1;
					end
					gpm_pkg::OP_CLR: begin
						plen_q <= '0;
						ptl_q <= 1'b0;
					end
					default: ;
				endcase
			end
			if (st_q == gpm_pkg::ST_DONE) begin
				vlen_q <= '0;
				vtl_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		pi_q <= pi_d; spi_q <= spi_d; cs_q <= cs_d;
		vi_q <= vi_d; svi_q <= svi_d;
		hs_q <= hs_d; neg_q <= neg_d; hit_q <= hit_d; mode_q <= mode_d;
		sub_q <= sub_d; lo_q <= lo_d; c_q <= c_d;
		valid_q <= valid_d; res_q <= res_d;
	end

	// pattern end test on any index
	function automatic logic pend(input logic [gpm_pkg::PLW:0] i,
		input logic [gpm_pkg::PLW-1:0] n);
		pend = (i >= {1'b0, n});
	endfunction

	logic [gpm_pkg::PLW:0] pi1;
	logic pe, pe1;
	logic [7:0] p;
	assign pi1 = pi_q + 1'b1;
	assign pe = pend(pi_q, plen_q);
	assign pe1 = pend(pi1, plen_q);
	assign p = prd_q;

	assign busy = (st_q != gpm_pkg::ST_IDLE);
	assign done = (st_q == gpm_pkg::ST_DONE);
	assign matched = res_q;
	assign pattern_valid = valid_q;
	assign overflow = vtl_q;

	// sub_q in check mode: 0 top, 1 after '[' (neg test), 2 after neg (']' test), 3 body
	always_comb begin
		st_d = st_q;
		pi_d = pi_q; spi_d = spi_q; cs_d = cs_q; vi_d = vi_q; svi_d = svi_q;
		hs_d = hs_q; neg_d = neg_q; hit_d = hit_q; mode_d = mode_q;
		sub_d = sub_q; lo_d = lo_q; c_d = c_q; valid_d = valid_q; res_d = res_q;
		rd_i = pi_q;
		vraddr = vi_q[gpm_pkg::VAW-1:0];
		case (st_q)
			gpm_pkg::ST_IDLE: begin
				if (acc && gpm_pkg::op_t'(operation) == gpm_pkg::OP_EVAL) begin
					pi_d = '0; sub_d = 2'd0; mode_d = 1'b0;
					if (ptl_q || plen_q == '0) begin
						valid_d = 1'b0; res_d = 1'b0; st_d = gpm_pkg::ST_DONE;
					end else begin
						st_d = gpm_pkg::ST_CHK_RD;
					end
				end
			end
			gpm_pkg::ST_CHK_RD: begin
				if (pe) begin
					if (sub_q == 2'd0) begin
						valid_d = 1'b1;
						pi_d = '0; vi_d = '0; hs_d = 1'b0; mode_d = 1'b0;
						st_d = vtl_q ? gpm_pkg::ST_DONE : gpm_pkg::ST_M_RD;
						res_d = 1'b0;
					end else begin
						valid_d = 1'b0; res_d = 1'b0; st_d = gpm_pkg::ST_DONE;
					end
				end else st_d = gpm_pkg::ST_CHK;
			end
			gpm_pkg::ST_CHK: begin
				st_d = gpm_pkg::ST_CHK_RD;
				pi_d = pi1;
				if (mode_q) begin
					mode_d = 1'b0;
				end else if (sub_q == 2'd0 && (p < gpm_pkg::CH_SP || p == gpm_pkg::CH_DEL)) begin
					valid_d = 1'b0; res_d = 1'b0; st_d = gpm_pkg::ST_DONE;
				end else begin
					case (sub_q)
						2'd0: begin
							if (p == gpm_pkg::CH_BSL) begin
								if (pe1) begin valid_d = 1'b0; res_d = 1'b0;
									st_d = gpm_pkg::ST_DONE; end
								else mode_d = 1'b1;
							end else if (p == gpm_pkg::CH_LB) sub_d = 2'd1;
						end
						2'd1: begin
							if (p == gpm_pkg::CH_BANG || p == gpm_pkg::CH_CARET) sub_d = 2'd2;
							else if (p == gpm_pkg::CH_RB) sub_d = 2'd3;
							else begin sub_d = 2'd3; pi_d = pi_q; end
						end
						2'd2: begin
							sub_d = 2'd3;
							if (p != gpm_pkg::CH_RB) pi_d = pi_q;
						end
						default: begin
							if (p == gpm_pkg::CH_BSL) begin
								if (pe1) begin valid_d = 1'b0; res_d = 1'b0;
									st_d = gpm_pkg::ST_DONE; end
								else mode_d = 1'b1;
							end else if (p == gpm_pkg::CH_RB) sub_d = 2'd0;
						end
					endcase
				end
			end
			gpm_pkg::ST_M_RD: begin
				if (vi_q >= vlen_q) st_d = gpm_pkg::ST_TAIL_RD;
				else st_d = gpm_pkg::ST_M;
			end
			gpm_pkg::ST_M: begin
				c_d = vrd_q;
				if (pe) begin
					hit_d = 1'b0; cs_d = '0; st_d = gpm_pkg::ST_CL_DASH2;
					mode_d = 1'b1;
				end else if (p == gpm_pkg::CH_STAR) begin
					hs_d = 1'b1; spi_d = pi_q; svi_d = vi_q; pi_d = pi1;
					st_d = gpm_pkg::ST_M_RD;
				end else if (p == gpm_pkg::CH_BSL && !pe1) begin
					pi_d = pi1; st_d = gpm_pkg::ST_ESC_RD;
				end else if (p == gpm_pkg::CH_QM) begin
					pi_d = pi1; vi_d = vi_q + 1'b1; st_d = gpm_pkg::ST_M_RD;
				end else if (p == gpm_pkg::CH_LB) begin
					cs_d = pi_q; pi_d = pi1; neg_d = 1'b0; hit_d = 1'b0; sub_d = 2'd0;
					st_d = gpm_pkg::ST_CL_RD;
				end else begin
					hit_d = (p == vrd_q); cs_d = pi1; st_d = gpm_pkg::ST_CL_DASH2;
					mode_d = 1'b1;
				end
			end
			gpm_pkg::ST_ESC_RD: st_d = gpm_pkg::ST_ESC;
			gpm_pkg::ST_ESC: begin
				hit_d = (p == c_q); cs_d = pi1; mode_d = 1'b1;
				st_d = gpm_pkg::ST_CL_DASH2;
			end
			// class: sub 0 neg test, 1 ']' first test, 2 body
			gpm_pkg::ST_CL_RD: st_d = gpm_pkg::ST_CL;
			gpm_pkg::ST_CL: begin
				st_d = gpm_pkg::ST_CL_RD;
				case (sub_q)
					2'd0: begin
						sub_d = 2'd1;
						if (!pe && (p == gpm_pkg::CH_BANG || p == gpm_pkg::CH_CARET)) begin
							neg_d = 1'b1; pi_d = pi1;
						end
					end
					2'd1: begin
						sub_d = 2'd2;
						if (!pe && p == gpm_pkg::CH_RB) begin
							hit_d = (c_q == gpm_pkg::CH_RB); pi_d = pi1;
						end
					end
					default: begin
						if (pe || p == gpm_pkg::CH_RB) begin
							cs_d = pe ? pi_q : pi1;
							hit_d = hit_q ^ neg_q;
							mode_d = 1'b1;
							st_d = gpm_pkg::ST_CL_DASH2;
						end else begin
							lo_d = p; pi_d = pi1;
							st_d = (p == gpm_pkg::CH_BSL && !pe1) ?
								gpm_pkg::ST_CL_LO : gpm_pkg::ST_CL_DASH;
						end
					end
				endcase
			end
			gpm_pkg::ST_CL_LO: st_d = gpm_pkg::ST_CL_LOE;
			gpm_pkg::ST_CL_LOE: begin
				lo_d = p; pi_d = pi1; st_d = gpm_pkg::ST_CL_DASH;
				mode_d = 1'b0;
			end
			gpm_pkg::ST_CL_DASH: begin
				// read pi then pi+1 via two reads
				st_d = gpm_pkg::ST_CL_HI; sub_d = 2'd0; mode_d = 1'b0;
			end
			gpm_pkg::ST_CL_HI: begin
				if (!mode_q) begin
					if (!pe && p == gpm_pkg::CH_DASH && !pe1) begin
						mode_d = 1'b1; rd_i = pi1; st_d = gpm_pkg::ST_CL_HIE;
					end else begin
						if (lo_q == c_q) hit_d = 1'b1;
						sub_d = 2'd2; st_d = gpm_pkg::ST_CL_RD;
					end
				end
			end
			gpm_pkg::ST_CL_HIE: begin
				// p = byte at pi+1 when mode_q; sub_q 0 first look, 1 escaped hi
				if (sub_q == 2'd0) begin
					if (p == gpm_pkg::CH_RB) begin
						if (lo_q == c_q) hit_d = 1'b1;
						sub_d = 2'd2; st_d = gpm_pkg::ST_CL_RD;
					end else if (p == gpm_pkg::CH_BSL && !pend(pi_q + 2'd2, plen_q)) begin
						pi_d = pi_q + 2'd3; rd_i = pi_q + 2'd2; sub_d = 2'd1;
					end else begin
						if (lo_q <= c_q && c_q <= p) hit_d = 1'b1;
						pi_d = pi_q + 2'd2; sub_d = 2'd2; st_d = gpm_pkg::ST_CL_RD;
					end
				end else begin
					if (lo_q <= c_q && c_q <= p) hit_d = 1'b1;
					sub_d = 2'd2; st_d = gpm_pkg::ST_CL_RD;
				end
			end
			gpm_pkg::ST_CL_DASH2: begin
				// resolve single-char outcome: hit_q, cs_q = next pi
				if (hit_q) begin
					pi_d = cs_q; vi_d = vi_q + 1'b1; st_d = gpm_pkg::ST_M_RD;
				end else if (hs_q) begin
					pi_d = spi_q + 1'b1; svi_d = svi_q + 1'b1; vi_d = svi_q + 1'b1;
					st_d = gpm_pkg::ST_M_RD;
				end else begin
					res_d = 1'b0; st_d = gpm_pkg::ST_DONE;
				end
			end
			gpm_pkg::ST_TAIL_RD: begin
				if (pe) begin res_d = 1'b1; st_d = gpm_pkg::ST_DONE; end
				else st_d = gpm_pkg::ST_TAIL;
			end
			gpm_pkg::ST_TAIL: begin
				if (p == gpm_pkg::CH_STAR) begin pi_d = pi1; st_d = gpm_pkg::ST_TAIL_RD; end
				else begin res_d = 1'b0; st_d = gpm_pkg::ST_DONE; end
			end
			gpm_pkg::ST_DONE: st_d = gpm_pkg::ST_IDLE;
			default: st_d = gpm_pkg::ST_IDLE;
		endcase
		praddr = rd_i[gpm_pkg::PAW-1:0];
	end

	`GPM_ASSERT_IMP(a_done_busy, done, busy)
	`GPM_ASSERT_IMP(a_match_valid, done && matched, pattern_valid && !overflow)
	`GPM_ASSERT_NXT(a_done_idle, done, !busy)
	`GPM_ASSERT_IMP(a_plen_bound, 1'b1, plen_q <= gpm_pkg::PLW'(gpm_pkg::PATTERN_MAX))
endmodule
`default_nettype wire
